// File: hdl/timestamp_frame_interleaver_macros.svh
// Assertion helpers shared by the interleaver RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef TIMESTAMP_FRAME_INTERLEAVER_MACROS_SVH
`define TIMESTAMP_FRAME_INTERLEAVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TFI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TFI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tfi_pkg.sv
package tfi_pkg;

	// Field widths
	localparam int TIME_W   = 64;
	localparam int DUR_W    = 32;
	localparam int BYTES_W  = 32;
	localparam int TRACK_W  = 8;
	localparam int OTRACK_W = 4;
	localparam int NUMTR_W  = 4;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_TRACKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd2;

	// Register reset values
	localparam logic [NUMTR_W-1:0] RST_NUM_TRACKS = 4'd1;
	localparam logic [BYTES_W-1:0] RST_BYTE_LIMIT = 32'(1024 * 1024);
	localparam logic [DUR_W-1:0]   RST_TIME_LIMIT = 32'd5000;

	// Request opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Microprogram addresses
	typedef logic [3:0] step_t;
	localparam step_t STEP_IDLE    = 4'd0;
	localparam step_t STEP_DISP    = 4'd1;
	localparam step_t STEP_CHK     = 4'd2;
	localparam step_t STEP_A_RD    = 4'd3;
	localparam step_t STEP_A_LD    = 4'd4;
	localparam step_t STEP_A_CALC  = 4'd5;
	localparam step_t STEP_A_EMIT  = 4'd6;
	localparam step_t STEP_A_STORE = 4'd7;
	localparam step_t STEP_F_INIT  = 4'd8;
	localparam step_t STEP_F_SCAN  = 4'd9;
	localparam step_t STEP_F_TAIL  = 4'd10;
	localparam step_t STEP_F_CHK   = 4'd11;
	localparam step_t STEP_F_CALC  = 4'd12;
	localparam step_t STEP_F_EMIT  = 4'd13;
	localparam step_t STEP_BAD     = 4'd14;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_READ_SLOT,
		ACT_LOAD_REL,
		ACT_CALC,
		ACT_EMIT_ADD,
		ACT_STORE,
		ACT_SCAN_INIT,
		ACT_SCAN,
		ACT_EMIT_FLUSH,
		ACT_EMIT_BAD
	} act_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_IN,
		COND_IS_FLUSH,
		COND_IS_BAD,
		COND_SLOT_EMPTY,
		COND_SCAN_MORE,
		COND_NONE_FOUND
	} cond_t;

	// One control word: datapath action, jump condition, output wait, jump target
	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  wait_out;
		step_t target;
	} ctrl_t;

	// Held frame as stored in the slot memory
	typedef struct packed {
		logic [TIME_W-1:0]  tc;
		logic [DUR_W-1:0]   dur;
		logic [BYTES_W-1:0] nbytes;
	} slot_t;

	// Result item
	typedef struct packed {
		logic                frame_valid;
		logic [OTRACK_W-1:0] out_track;
		logic [TIME_W-1:0]   out_time;
		logic [DUR_W-1:0]    out_duration;
		logic [BYTES_W-1:0]  out_bytes;
		logic                cluster_start;
		logic [TIME_W-1:0]   end_time;
		logic                bad_track;
		logic                last;
	} res_t;

	// Microprogram ROM
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		unique case (s)
			STEP_IDLE:    w = '{ACT_ACCEPT,     COND_NO_IN,      1'b0, STEP_IDLE};
			STEP_DISP:    w = '{ACT_NONE,       COND_IS_FLUSH,   1'b0, STEP_F_INIT};
			STEP_CHK:     w = '{ACT_NONE,       COND_IS_BAD,     1'b0, STEP_BAD};
			STEP_A_RD:    w = '{ACT_READ_SLOT,  COND_SLOT_EMPTY, 1'b0, STEP_A_STORE};
			STEP_A_LD:    w = '{ACT_LOAD_REL,   COND_NEVER,      1'b0, STEP_IDLE};
			STEP_A_CALC:  w = '{ACT_CALC,       COND_NEVER,      1'b0, STEP_IDLE};
			STEP_A_EMIT:  w = '{ACT_EMIT_ADD,   COND_NEVER,      1'b1, STEP_IDLE};
			STEP_A_STORE: w = '{ACT_STORE,      COND_ALWAYS,     1'b0, STEP_IDLE};
			STEP_F_INIT:  w = '{ACT_SCAN_INIT,  COND_NEVER,      1'b0, STEP_IDLE};
			STEP_F_SCAN:  w = '{ACT_SCAN,       COND_SCAN_MORE,  1'b0, STEP_F_SCAN};
			STEP_F_TAIL:  w = '{ACT_NONE,       COND_NEVER,      1'b0, STEP_IDLE};
			STEP_F_CHK:   w = '{ACT_NONE,       COND_NONE_FOUND, 1'b0, STEP_IDLE};
			STEP_F_CALC:  w = '{ACT_CALC,       COND_NEVER,      1'b0, STEP_IDLE};
			STEP_F_EMIT:  w = '{ACT_EMIT_FLUSH, COND_ALWAYS,     1'b1, STEP_F_INIT};
			STEP_BAD:     w = '{ACT_EMIT_BAD,   COND_ALWAYS,     1'b1, STEP_IDLE};
			default:      w = '{ACT_NONE,       COND_ALWAYS,     1'b0, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: hdl/tfi_frame_if.sv
interface tfi_frame_if;
	import tfi_pkg::*;

	logic                valid;
	logic                ready;
	logic                opcode;
	logic [TRACK_W-1:0]  track_number;
	logic [TIME_W-1:0]   frame_time;
	logic [DUR_W-1:0]    frame_duration;
	logic [BYTES_W-1:0]  frame_bytes;

	modport source (
		output valid, opcode, track_number, frame_time, frame_duration, frame_bytes,
		input  ready
	);
	modport sink (
		input  valid, opcode, track_number, frame_time, frame_duration, frame_bytes,
		output ready
	);
endinterface

// File: hdl/tfi_result_if.sv
interface tfi_result_if;
	import tfi_pkg::*;

	logic                valid;
	logic                ready;
	logic                frame_valid;
	logic [OTRACK_W-1:0] out_track;
	logic [TIME_W-1:0]   out_time;
	logic [DUR_W-1:0]    out_duration;
	logic [BYTES_W-1:0]  out_bytes;
	logic                cluster_start;
	logic [TIME_W-1:0]   end_time;
	logic                bad_track;
	logic                last;

	modport source (
		output valid, frame_valid, out_track, out_time, out_duration, out_bytes,
		       cluster_start, end_time, bad_track, last,
		input  ready
	);
	modport sink (
		input  valid, frame_valid, out_track, out_time, out_duration, out_bytes,
		       cluster_start, end_time, bad_track, last,
		output ready
	);
endinterface

// File: hdl/timestamp_frame_interleaver.sv
// Add to an empty slot: the request is dispatched, checked, its slot read, and the frame stored.
// Add that releases a frame: the held frame is loaded and its result registered, then the new one stored.
// Bad track: a result with bad_track set is registered; output stalls hold the emit step.
// Flush: each held frame is released, earliest first, after a scan of all MAX_TRACKS slots,
// and a closing scan that finds no held frame ends it; the slot scan does one read a cycle.
// arst_n clears held slots, cluster state, registers to defaults and the step counter.
`include "timestamp_frame_interleaver_macros.svh"

module timestamp_frame_interleaver #(
	parameter int MAX_TRACKS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tfi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tfi_pkg::CFG_W-1:0]     cfg_data,
	tfi_frame_if.sink                     frames,
	tfi_result_if.source                  results
);
	import tfi_pkg::*;

	localparam int SLOT_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int REM_W  = $clog2(MAX_TRACKS + 1);
	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(MAX_TRACKS - 1);
	localparam logic [TRACK_W-1:0] MAX_TRK   = TRACK_W'(MAX_TRACKS);

	// Sequencer
	step_t step_q, step_d;
	ctrl_t cw;
	logic  cond_hit, out_free, stall, accept;
	logic  do_accept, do_read_slot, do_load, do_calc, do_emit_add, do_store;
	logic  do_scan_init, do_scan, do_emit_flush, do_emit_bad, do_emit;

	// Configuration
	logic [NUMTR_W-1:0] num_tracks_q;
	logic [BYTES_W-1:0] byte_limit_q;
	logic [DUR_W-1:0]   time_limit_q;

	// Captured request
	logic               op_q;
	logic [TRACK_W-1:0] trk_q;
	logic [TIME_W-1:0]  ftime_q;
	logic [DUR_W-1:0]   fdur_q;
	logic [BYTES_W-1:0] fbytes_q;
	logic [TRACK_W-1:0] ntr, trk_m1;
	logic [SLOT_W-1:0]  add_slot;
	logic               trk_bad;

	// Slot store
	logic [MAX_TRACKS-1:0] held_valid_q;
	slot_t                 mem_q [MAX_TRACKS];
	slot_t                 rdata_q;
	logic                  rd_en;
	logic [SLOT_W-1:0]     rd_addr;

	// Scan
	logic [SLOT_W-1:0] scan_q, scan_idx_s1;
	logic              scan_v_s1, found_q, scan_hit, scan_take;
	logic [REM_W-1:0]  rem_q;

	// Release candidate and cluster state
	logic [TIME_W-1:0]  rel_tc_q;
	logic [DUR_W-1:0]   rel_dur_q;
	logic [BYTES_W-1:0] rel_bytes_q;
	logic [SLOT_W-1:0]  rel_slot_q;
	logic               start_q;
	logic [TIME_W-1:0]  end_sum_q;
	logic               cluster_open_q;
	logic [TIME_W-1:0]  cluster_base_q;
	logic [BYTES_W-1:0] cluster_bytes_q;
	logic [TIME_W-1:0]  latest_end_q;
	logic [BYTES_W-1:0] bytes_base, bytes_new;
	logic [BYTES_W:0]   bytes_sum;
	logic [TIME_W-1:0]  end_new;
	logic [TRACK_W-1:0] trk_out;
	logic               emit_last;

	// Output register
	logic out_v_q;
	res_t res_q;

	// Fetch control word
	assign cw       = ucode(step_q);
	assign out_free = !out_v_q || results.ready;
	assign stall    = cw.wait_out && !out_free;

	assign frames.ready = (cw.act == ACT_ACCEPT);
	assign accept       = frames.valid && frames.ready;

	// Request checks
	assign ntr      = ({4'b0, num_tracks_q} > MAX_TRK) ? MAX_TRK : {4'b0, num_tracks_q};
	assign trk_bad  = (trk_q == '0) || (trk_q > ntr);
	assign trk_m1   = trk_q - 8'd1;
	assign add_slot = trk_m1[SLOT_W-1:0];

	// Evaluate jump condition
	always_comb begin
		unique case (cw.cond)
			COND_NEVER:      cond_hit = 1'b0;
			COND_ALWAYS:     cond_hit = 1'b1;
			COND_NO_IN:      cond_hit = !frames.valid;
			COND_IS_FLUSH:   cond_hit = (op_q == OP_FLUSH);
			COND_IS_BAD:     cond_hit = trk_bad;
			COND_SLOT_EMPTY: cond_hit = !held_valid_q[add_slot];
			COND_SCAN_MORE:  cond_hit = (scan_q != LAST_SLOT);
			COND_NONE_FOUND: cond_hit = !found_q;
			default:         cond_hit = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		if (stall) begin
			step_d = step_q;
		end else if (cond_hit) begin
			step_d = cw.target;
		end else begin
			step_d = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Decode datapath strobes
	always_comb begin
		do_accept     = 1'b0;
		do_read_slot  = 1'b0;
		do_load       = 1'b0;
		do_calc       = 1'b0;
		do_emit_add   = 1'b0;
		do_store      = 1'b0;
		do_scan_init  = 1'b0;
		do_scan       = 1'b0;
		do_emit_flush = 1'b0;
		do_emit_bad   = 1'b0;
		if (!stall) begin
			unique case (cw.act)
				ACT_NONE:       ;
				ACT_ACCEPT:     do_accept     = accept;
				ACT_READ_SLOT:  do_read_slot  = 1'b1;
				ACT_LOAD_REL:   do_load       = 1'b1;
				ACT_CALC:       do_calc       = 1'b1;
				ACT_EMIT_ADD:   do_emit_add   = 1'b1;
				ACT_STORE:      do_store      = 1'b1;
				ACT_SCAN_INIT:  do_scan_init  = 1'b1;
				ACT_SCAN:       do_scan       = 1'b1;
				ACT_EMIT_FLUSH: do_emit_flush = 1'b1;
				ACT_EMIT_BAD:   do_emit_bad   = 1'b1;
				default:        ;
			endcase
		end
	end

	assign do_emit = do_emit_add || do_emit_flush;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tracks_q <= RST_NUM_TRACKS;
			byte_limit_q <= RST_BYTE_LIMIT;
			time_limit_q <= RST_TIME_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_TRACKS: num_tracks_q <= cfg_data[NUMTR_W-1:0];
				REG_BYTE_LIMIT: byte_limit_q <= cfg_data[BYTES_W-1:0];
				REG_TIME_LIMIT: time_limit_q <= cfg_data[DUR_W-1:0];
				default:        ;
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (do_accept) begin
			op_q     <= frames.opcode;
			trk_q    <= frames.track_number;
			ftime_q  <= frames.frame_time;
			fdur_q   <= frames.frame_duration;
			fbytes_q <= frames.frame_bytes;
		end
	end

	// Slot memory: one write, one registered read
	assign rd_en   = do_read_slot || do_scan;
	assign rd_addr = do_scan ? scan_q : add_slot;

	always_ff @(posedge clk) begin
		if (do_store) begin
			mem_q[add_slot] <= '{tc: ftime_q, dur: fdur_q, nbytes: fbytes_q};
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= '0;
		end else if (do_store) begin
			held_valid_q[add_slot] <= 1'b1;
		end else if (do_emit_flush) begin
			held_valid_q[rel_slot_q] <= 1'b0;
		end
	end

	// Scan for the earliest held frame; ties keep the lower slot
	assign scan_hit  = scan_v_s1 && held_valid_q[scan_idx_s1];
	assign scan_take = scan_hit && (!found_q || (rdata_q.tc < rel_tc_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			scan_idx_s1 <= '0;
			scan_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			rem_q       <= '0;
		end else begin
			scan_v_s1   <= do_scan;
			scan_idx_s1 <= scan_q;
			if (do_scan_init) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				rem_q   <= '0;
			end else begin
				if (do_scan) begin
					scan_q <= scan_q + SLOT_W'(1);
				end
				if (scan_hit) begin
					rem_q <= rem_q + REM_W'(1);
				end
				if (scan_take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Load the release candidate
	always_ff @(posedge clk) begin
		if (do_load) begin
			rel_tc_q    <= rdata_q.tc;
			rel_dur_q   <= rdata_q.dur;
			rel_bytes_q <= rdata_q.nbytes;
			rel_slot_q  <= add_slot;
		end else if (scan_take) begin
			rel_tc_q    <= rdata_q.tc;
			rel_dur_q   <= rdata_q.dur;
			rel_bytes_q <= rdata_q.nbytes;
			rel_slot_q  <= scan_idx_s1;
		end
	end

	// Decide cluster start and frame end ahead of the emit step
	always_ff @(posedge clk) begin
		if (do_calc) begin
			start_q <= !cluster_open_q
				|| ((rel_tc_q - cluster_base_q) >= TIME_W'(time_limit_q))
				|| (cluster_bytes_q >= byte_limit_q);
			end_sum_q <= rel_tc_q + TIME_W'(rel_dur_q);
		end
	end

	// Saturating byte count and latest end
	assign bytes_base = start_q ? '0 : cluster_bytes_q;
	assign bytes_sum  = {1'b0, bytes_base} + {1'b0, rel_bytes_q};
	assign bytes_new  = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
	assign end_new    = (end_sum_q > latest_end_q) ? end_sum_q : latest_end_q;
	assign trk_out    = TRACK_W'(rel_slot_q) + 8'd1;
	assign emit_last  = do_emit_add || (rem_q == REM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_open_q  <= 1'b0;
			cluster_base_q  <= '0;
			cluster_bytes_q <= '0;
			latest_end_q    <= '0;
		end else if (do_emit) begin
			cluster_open_q  <= 1'b1;
			cluster_bytes_q <= bytes_new;
			latest_end_q    <= end_new;
			if (start_q) begin
				cluster_base_q <= rel_tc_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (do_emit || do_emit_bad) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			res_q <= '{
				frame_valid:   1'b1,
				out_track:     trk_out[OTRACK_W-1:0],
				out_time:      rel_tc_q,
				out_duration:  rel_dur_q,
				out_bytes:     rel_bytes_q,
				cluster_start: start_q,
				end_time:      end_new,
				bad_track:     1'b0,
				last:          emit_last
			};
		end else if (do_emit_bad) begin
			res_q <= '{
				frame_valid:   1'b0,
				out_track:     '0,
				out_time:      '0,
				out_duration:  '0,
				out_bytes:     '0,
				cluster_start: 1'b0,
				end_time:      latest_end_q,
				bad_track:     1'b1,
				last:          1'b1
			};
		end
	end

	assign results.valid         = out_v_q;
	assign results.frame_valid   = res_q.frame_valid;
	assign results.out_track     = res_q.out_track;
	assign results.out_time      = res_q.out_time;
	assign results.out_duration  = res_q.out_duration;
	assign results.out_bytes     = res_q.out_bytes;
	assign results.cluster_start = res_q.cluster_start;
	assign results.end_time      = res_q.end_time;
	assign results.bad_track     = res_q.bad_track;
	assign results.last          = res_q.last;

	// Checks
	`TFI_ASSERT_SAME(a_emit_room, do_emit || do_emit_bad, out_free, "result loaded over a waiting one")
	`TFI_ASSERT_SAME(a_flush_held, do_emit_flush, held_valid_q[rel_slot_q], "released an empty slot")
	`TFI_ASSERT_SAME(a_store_good, do_store, (op_q == OP_ADD) && !trk_bad, "stored a bad request")
	`TFI_ASSERT_NEXT(a_accept_disp, accept, step_q == STEP_DISP, "accept did not dispatch")

endmodule
